// ----- sv/ts_header_adaptation_parser_defines.svh -----
// Assertion macros for the transport stream header parser checkers.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TS_HEADER_ADAPTATION_PARSER_DEFINES_SVH
`define TS_HEADER_ADAPTATION_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSHAP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSHAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tshap_pkg.sv -----
// Shared widths, flag masks, parse phase type and helper functions
// for the transport stream header / adaptation field parser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tshap_pkg;

    localparam int DATA_W  = 8;
    localparam int PID_W   = 13;
    localparam int CLOCK_W = 42;
    localparam int SHIFT_W = 48;

    localparam logic [7:0] SYNC_BYTE     = 8'h47;
    localparam logic [7:0] LAST_BYTE_POS = 8'd187;
    localparam logic [7:0] HDR_LAST_POS  = 8'd3;
    localparam logic [7:0] CLOCK_BYTES   = 8'd6;

    // Optional-field flags, bits [4:0] of the adaptation flags byte
    localparam logic [4:0] PCR_FLAG    = 5'b10000;
    localparam logic [4:0] OPCR_FLAG   = 5'b01000;
    localparam logic [4:0] SPLICE_FLAG = 5'b00100;
    localparam logic [4:0] PRIV_FLAG   = 5'b00010;
    localparam logic [4:0] EXT_FLAG    = 5'b00001;

    // Fields still open after a given field is done
    localparam logic [4:0] AFTER_FLAGS  = 5'b11111;
    localparam logic [4:0] AFTER_PCR    = 5'b01111;
    localparam logic [4:0] AFTER_OPCR   = 5'b00111;
    localparam logic [4:0] AFTER_SPLICE = 5'b00011;
    localparam logic [4:0] AFTER_PRIV   = 5'b00001;

    localparam logic [7:0] CLOCK_COST = 8'd6;
    localparam logic [7:0] BYTE_COST  = 8'd1;

    typedef enum logic [12:0] {
        PH_IDLE     = 13'b0000000000001,
        PH_HDR      = 13'b0000000000010,
        PH_AFLEN    = 13'b0000000000100,
        PH_FLAGS    = 13'b0000000001000,
        PH_PCR      = 13'b0000000010000,
        PH_OPCR     = 13'b0000000100000,
        PH_SPLICE   = 13'b0000001000000,
        PH_PRIVLEN  = 13'b0000010000000,
        PH_PRIVSKIP = 13'b0000100000000,
        PH_EXTLEN   = 13'b0001000000000,
        PH_EXTSKIP  = 13'b0010000000000,
        PH_STUFF    = 13'b0100000000000,
        PH_DONE     = 13'b1000000000000
    } phase_t;

    typedef struct packed {
        logic               found;
        phase_t             phase;
        logic [7:0]         cost;
    } advance_t;

    typedef struct packed {
        logic               sync_error;
        logic [2:0]         header_flags;
        logic [PID_W-1:0]   packet_id;
        logic [1:0]         scrambling;
        logic [1:0]         field_control;
        logic [3:0]         continuity;
        logic [7:0]         af_length;
        logic [7:0]         af_flags;
        logic [CLOCK_W-1:0] pcr_value;
        logic [CLOCK_W-1:0] opcr_value;
        logic [7:0]         splice_countdown;
        logic [7:0]         stuffing_count;
    } result_t;

    // First pending optional field in stream order
    function automatic advance_t next_field(logic [4:0] pending);
        advance_t a;
        a = '{found: 1'b1, phase: PH_STUFF, cost: 8'd0};
        priority if ((pending & PCR_FLAG) != 5'd0)
        begin
            a.phase = PH_PCR;
            a.cost  = CLOCK_COST;
        end
        else if ((pending & OPCR_FLAG) != 5'd0)
        begin
            a.phase = PH_OPCR;
            a.cost  = CLOCK_COST;
        end
        else if ((pending & SPLICE_FLAG) != 5'd0)
        begin
            a.phase = PH_SPLICE;
            a.cost  = BYTE_COST;
        end
        else if ((pending & PRIV_FLAG) != 5'd0)
        begin
            a.phase = PH_PRIVLEN;
            a.cost  = BYTE_COST;
        end
        else if ((pending & EXT_FLAG) != 5'd0)
        begin
            a.phase = PH_EXTLEN;
            a.cost  = BYTE_COST;
        end
        else
        begin
            a.found = 1'b0;
        end
        return a;
    endfunction

    function automatic logic [7:0] sat_add8(logic [7:0] a, logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

    // 33-bit base * 300 + 9-bit extension; 300 = 256 + 32 + 8 + 4
    function automatic logic [CLOCK_W-1:0] clock_value(logic [SHIFT_W-1:0] sh);
        logic [CLOCK_W-1:0] base;
        logic [CLOCK_W-1:0] ext;
        base = CLOCK_W'(sh[47:15]);
        ext  = CLOCK_W'(sh[8:0]);
        return (base << 8) + (base << 5) + (base << 3) + (base << 2) + ext;
    endfunction

endpackage

`default_nettype wire

// ----- sv/tshap_if.sv -----
// Valid/ready channel interfaces for packet bytes and parse results.
// Depends on tshap_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tshap_byte_if;
    logic                        valid;
    logic                        ready;
    logic [tshap_pkg::DATA_W-1:0] data_byte;
    logic                        packet_start;

    modport source (output valid, output data_byte, output packet_start, input ready);
    modport sink   (input valid, input data_byte, input packet_start, output ready);
endinterface

interface tshap_result_if;
    logic                          valid;
    logic                          ready;
    logic                          sync_error;
    logic [2:0]                    header_flags;
    logic [tshap_pkg::PID_W-1:0]   packet_id;
    logic [1:0]                    scrambling;
    logic [1:0]                    field_control;
    logic [3:0]                    continuity;
    logic [7:0]                    af_length;
    logic [7:0]                    af_flags;
    logic [tshap_pkg::CLOCK_W-1:0] pcr_value;
    logic [tshap_pkg::CLOCK_W-1:0] opcr_value;
    logic [7:0]                    splice_countdown;
    logic [7:0]                    stuffing_count;

    modport source (output valid, output sync_error, output header_flags, output packet_id,
                    output scrambling, output field_control, output continuity,
                    output af_length, output af_flags, output pcr_value, output opcr_value,
                    output splice_countdown, output stuffing_count, input ready);
    modport sink   (input valid, input sync_error, input header_flags, input packet_id,
                    input scrambling, input field_control, input continuity,
                    input af_length, input af_flags, input pcr_value, input opcr_value,
                    input splice_countdown, input stuffing_count, output ready);
endinterface

`default_nettype wire

// ----- sv/ts_header_adaptation_parser.sv -----
// Transport stream packet header and adaptation field parser, top level.
// Depends on tshap_pkg and the channel interfaces in tshap_if.sv.
//
// Channel     Role    Payload
// byte_ch     sink    data_byte[7:0], packet_start
// result_ch   source  sync_error, header fields, adaptation fields, PCR/OPCR, stuffing
//
// One byte per cycle while ready is high. Parse state advances in the cycle a byte is taken;
// the result lands in the output register at the edge that takes the last byte it needs.
// PCR/OPCR are formed by a shift-add (x300) between the shift register and the result.
// byte_ch.ready drops only while a result sits in the output register and is not taken.
// rst_n (async) returns the parser to idle with the output register empty.
`timescale 1ns / 1ps
`default_nettype none

module ts_header_adaptation_parser (
    input  wire               clk,
    input  wire               rst_n,
    tshap_byte_if.sink        byte_ch,
    tshap_result_if.source    result_ch
);

    tshap_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [23:0] hdr_reg, hdr_next;
    logic [7:0]  af_left_reg, af_left_next;
    logic [7:0]  flags_reg, flags_next;
    logic [tshap_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic [tshap_pkg::CLOCK_W-1:0] pcr_reg, pcr_next;
    logic [tshap_pkg::CLOCK_W-1:0] opcr_reg, opcr_next;
    logic [7:0]  splice_reg, splice_next;
    logic [7:0]  skip_reg, skip_next;
    logic [7:0]  used_reg, used_next;
    logic [7:0]  af_len_reg, af_len_next;

    logic                res_valid_reg, res_valid_next;
    tshap_pkg::result_t  res_reg, res_next;

    logic        accept;
    logic        emit;
    logic        sync_bad;
    logic        af_check;
    logic        do_adv;
    logic [4:0]  adv_mask;
    logic [7:0]  used_mid;
    logic [7:0]  pos_inc;
    logic [7:0]  left_dec;
    logic [7:0]  skip_inc;
    logic [7:0]  skip_dec;
    logic [23:0] hdr_sh;
    logic [tshap_pkg::SHIFT_W-1:0] shift_sh;
    tshap_pkg::advance_t adv;

    assign byte_ch.ready = !res_valid_reg || result_ch.ready;
    assign accept        = byte_ch.valid && byte_ch.ready;

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        hdr_next     = hdr_reg;
        af_left_next = af_left_reg;
        flags_next   = flags_reg;
        shift_next   = shift_reg;
        pcr_next     = pcr_reg;
        opcr_next    = opcr_reg;
        splice_next  = splice_reg;
        skip_next    = skip_reg;
        af_len_next  = af_len_reg;
        used_mid     = used_reg;
        emit         = 1'b0;
        sync_bad     = 1'b0;
        af_check     = 1'b0;
        do_adv       = 1'b0;
        adv_mask     = 5'd0;

        pos_inc  = (pos_reg != 8'hFF) ? pos_reg + 8'd1 : pos_reg;
        left_dec = (af_left_reg != 8'd0) ? af_left_reg - 8'd1 : af_left_reg;
        skip_inc = skip_reg + 8'd1;
        skip_dec = (skip_reg != 8'd0) ? skip_reg - 8'd1 : skip_reg;
        hdr_sh   = {hdr_reg[15:0], byte_ch.data_byte};
        shift_sh = {shift_reg[39:0], byte_ch.data_byte};

        if (accept)
        begin
            if (byte_ch.packet_start)
            begin
                pos_next     = 8'd0;
                af_left_next = 8'd0;
                flags_next   = 8'd0;
                shift_next   = '0;
                pcr_next     = '0;
                opcr_next    = '0;
                splice_next  = 8'd0;
                skip_next    = 8'd0;
                used_mid     = 8'd0;
                af_len_next  = 8'd0;
                if (byte_ch.data_byte != tshap_pkg::SYNC_BYTE)
                begin
                    hdr_next   = 24'd0;
                    phase_next = tshap_pkg::PH_IDLE;
                    emit       = 1'b1;
                    sync_bad   = 1'b1;
                end
                else
                begin
                    hdr_next   = {16'd0, tshap_pkg::SYNC_BYTE};
                    phase_next = tshap_pkg::PH_HDR;
                end
            end
            else if (phase_reg != tshap_pkg::PH_IDLE && phase_reg != tshap_pkg::PH_DONE)
            begin
                pos_next = pos_inc;
                if (phase_reg == tshap_pkg::PH_HDR)
                begin
                    hdr_next = hdr_sh;
                    if (pos_inc >= tshap_pkg::HDR_LAST_POS)
                    begin
                        if (hdr_sh[5])
                        begin
                            phase_next = tshap_pkg::PH_AFLEN;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                end
                else if (phase_reg == tshap_pkg::PH_AFLEN)
                begin
                    af_len_next  = byte_ch.data_byte;
                    af_left_next = byte_ch.data_byte;
                    if (byte_ch.data_byte == 8'd0)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        phase_next = tshap_pkg::PH_FLAGS;
                    end
                end
                else
                begin
                    af_left_next = left_dec;
                    af_check     = 1'b1;
                    unique case (phase_reg)
                        tshap_pkg::PH_FLAGS:
                        begin
                            flags_next = byte_ch.data_byte;
                            used_mid   = 8'd1;
                            do_adv     = 1'b1;
                            adv_mask   = tshap_pkg::AFTER_FLAGS;
                        end
                        tshap_pkg::PH_PCR, tshap_pkg::PH_OPCR:
                        begin
                            shift_next = shift_sh;
                            skip_next  = skip_inc;
                            if (skip_inc >= tshap_pkg::CLOCK_BYTES)
                            begin
                                do_adv = 1'b1;
                                if (phase_reg == tshap_pkg::PH_PCR)
                                begin
                                    pcr_next = tshap_pkg::clock_value(shift_sh);
                                    adv_mask = tshap_pkg::AFTER_PCR;
                                end
                                else
                                begin
                                    opcr_next = tshap_pkg::clock_value(shift_sh);
                                    adv_mask  = tshap_pkg::AFTER_OPCR;
                                end
                            end
                        end
                        tshap_pkg::PH_SPLICE:
                        begin
                            splice_next = byte_ch.data_byte;
                            do_adv      = 1'b1;
                            adv_mask    = tshap_pkg::AFTER_SPLICE;
                        end
                        tshap_pkg::PH_PRIVLEN, tshap_pkg::PH_EXTLEN:
                        begin
                            used_mid = tshap_pkg::sat_add8(used_reg, byte_ch.data_byte);
                            if (byte_ch.data_byte == 8'd0)
                            begin
                                do_adv   = 1'b1;
                                adv_mask = (phase_reg == tshap_pkg::PH_PRIVLEN) ?
                                           tshap_pkg::AFTER_PRIV : 5'd0;
                            end
                            else
                            begin
                                skip_next  = byte_ch.data_byte;
                                phase_next = (phase_reg == tshap_pkg::PH_PRIVLEN) ?
                                             tshap_pkg::PH_PRIVSKIP : tshap_pkg::PH_EXTSKIP;
                            end
                        end
                        tshap_pkg::PH_PRIVSKIP, tshap_pkg::PH_EXTSKIP:
                        begin
                            skip_next = skip_dec;
                            if (skip_dec == 8'd0)
                            begin
                                do_adv   = 1'b1;
                                adv_mask = (phase_reg == tshap_pkg::PH_PRIVSKIP) ?
                                           tshap_pkg::AFTER_PRIV : 5'd0;
                            end
                        end
                        default:
                        begin
                            // stuffing: only the length and position counters move
                        end
                    endcase
                end
            end
        end

        adv = tshap_pkg::next_field(flags_next[4:0] & adv_mask);
        used_next = used_mid;
        if (do_adv)
        begin
            phase_next = adv.phase;
            if (adv.found)
            begin
                used_next  = tshap_pkg::sat_add8(used_mid, adv.cost);
                skip_next  = 8'd0;
                shift_next = '0;
            end
        end

        // field exhausted, or the packet ran out before it did
        if (af_check && (af_left_next == 8'd0 || pos_next >= tshap_pkg::LAST_BYTE_POS))
        begin
            emit = 1'b1;
        end
        if (emit && !sync_bad)
        begin
            phase_next = tshap_pkg::PH_DONE;
        end
    end

    always_comb
    begin
        res_next = '0;
        if (sync_bad)
        begin
            res_next.sync_error = 1'b1;
        end
        else
        begin
            res_next.header_flags     = hdr_next[23:21];
            res_next.packet_id        = hdr_next[20:8];
            res_next.scrambling       = hdr_next[7:6];
            res_next.field_control    = hdr_next[5:4];
            res_next.continuity       = hdr_next[3:0];
            res_next.af_length        = af_len_next;
            res_next.af_flags         = flags_next;
            res_next.pcr_value        = pcr_next;
            res_next.opcr_value       = opcr_next;
            res_next.splice_countdown = splice_next;
            res_next.stuffing_count   = (af_len_next > used_next) ?
                                        af_len_next - used_next : 8'd0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept && emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tshap_pkg::PH_IDLE;
            pos_reg       <= 8'd0;
            hdr_reg       <= 24'd0;
            af_left_reg   <= 8'd0;
            flags_reg     <= 8'd0;
            shift_reg     <= '0;
            pcr_reg       <= '0;
            opcr_reg      <= '0;
            splice_reg    <= 8'd0;
            skip_reg      <= 8'd0;
            used_reg      <= 8'd0;
            af_len_reg    <= 8'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            hdr_reg       <= hdr_next;
            af_left_reg   <= af_left_next;
            flags_reg     <= flags_next;
            shift_reg     <= shift_next;
            pcr_reg       <= pcr_next;
            opcr_reg      <= opcr_next;
            splice_reg    <= splice_next;
            skip_reg      <= skip_next;
            used_reg      <= used_next;
            af_len_reg    <= af_len_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign result_ch.valid            = res_valid_reg;
    assign result_ch.sync_error       = res_reg.sync_error;
    assign result_ch.header_flags     = res_reg.header_flags;
    assign result_ch.packet_id        = res_reg.packet_id;
    assign result_ch.scrambling       = res_reg.scrambling;
    assign result_ch.field_control    = res_reg.field_control;
    assign result_ch.continuity       = res_reg.continuity;
    assign result_ch.af_length        = res_reg.af_length;
    assign result_ch.af_flags         = res_reg.af_flags;
    assign result_ch.pcr_value        = res_reg.pcr_value;
    assign result_ch.opcr_value       = res_reg.opcr_value;
    assign result_ch.splice_countdown = res_reg.splice_countdown;
    assign result_ch.stuffing_count   = res_reg.stuffing_count;

endmodule

`default_nettype wire

// ----- sv/tshap_checker.sv -----
// Port-level assertions for ts_header_adaptation_parser, attached by bind.
// Depends on ts_header_adaptation_parser_defines.svh and tshap_pkg widths.
`timescale 1ns / 1ps
`default_nettype none
`include "ts_header_adaptation_parser_defines.svh"

module tshap_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          byte_valid,
    input wire                          byte_ready,
    input wire                          result_valid,
    input wire                          result_ready,
    input wire                          sync_error,
    input wire [2:0]                    header_flags,
    input wire [tshap_pkg::PID_W-1:0]   packet_id,
    input wire [1:0]                    scrambling,
    input wire [1:0]                    field_control,
    input wire [3:0]                    continuity,
    input wire [7:0]                    af_length,
    input wire [7:0]                    af_flags,
    input wire [tshap_pkg::CLOCK_W-1:0] pcr_value,
    input wire [tshap_pkg::CLOCK_W-1:0] opcr_value,
    input wire [7:0]                    splice_countdown,
    input wire [7:0]                    stuffing_count
);

    // bad sync: header, adaptation length, PCR and stuffing fields are zero
    `TSHAP_ASSERT_IMPLY(a_sync_zero, clk, rst_n, result_valid && sync_error, header_flags == 3'd0 && packet_id == '0 && scrambling == 2'd0 && field_control == 2'd0 && continuity == 4'd0 && af_length == 8'd0 && pcr_value == '0 && stuffing_count == 8'd0, "sync error result carries nonzero fields")

    // no adaptation field, or an empty one: no adaptation data reported
    `TSHAP_ASSERT_IMPLY(a_no_af, clk, rst_n, result_valid && !sync_error && (!field_control[1] || af_length == 8'd0), af_flags == 8'd0 && pcr_value == '0 && opcr_value == '0 && splice_countdown == 8'd0 && stuffing_count == 8'd0, "adaptation data without adaptation field")

    `TSHAP_ASSERT_IMPLY(a_stuff_bound, clk, rst_n, result_valid, stuffing_count <= af_length, "stuffing count exceeds field length")

    // a new result only follows a byte transaction
    `TSHAP_ASSERT_IMPLY(a_result_cause, clk, rst_n, $rose(result_valid), $past(byte_valid && byte_ready), "result appeared without a byte transaction")

    `TSHAP_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(packet_id) && $stable(stuffing_count), "stalled result dropped or changed")

endmodule

bind ts_header_adaptation_parser tshap_checker u_tshap_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .byte_valid       (byte_ch.valid),
    .byte_ready       (byte_ch.ready),
    .result_valid     (result_ch.valid),
    .result_ready     (result_ch.ready),
    .sync_error       (result_ch.sync_error),
    .header_flags     (result_ch.header_flags),
    .packet_id        (result_ch.packet_id),
    .scrambling       (result_ch.scrambling),
    .field_control    (result_ch.field_control),
    .continuity       (result_ch.continuity),
    .af_length        (result_ch.af_length),
    .af_flags         (result_ch.af_flags),
    .pcr_value        (result_ch.pcr_value),
    .opcr_value       (result_ch.opcr_value),
    .splice_countdown (result_ch.splice_countdown),
    .stuffing_count   (result_ch.stuffing_count)
);

`default_nettype wire
